/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, widths and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// Default sizes handed to the top level parameters
	localparam int MAX_BLOCKS_DEF   = 1024;
	localparam int HEADER_BYTES_DEF = 32;

	// Field and register widths
	localparam int ADDR_W     = 32;
	localparam int BS_W       = 17;
	localparam int CNT_W      = 11;
	localparam int BYTES_W    = 27;
	localparam int DVD_W      = ADDR_W + 1;
	localparam int PROD_W     = CNT_W + BS_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Largest usable block size
	localparam logic [BS_W-1:0] BS_CAP = 17'h10000;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BSIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NBLK  = 2'd2;

	// Request kinds
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		OUT_DONE      = 2'd0,
		OUT_NO_SPACE  = 2'd1,
		OUT_NOT_ALLOC = 2'd2
	} outcome_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] request_bytes;
		logic [ADDR_W-1:0] release_address;
	} req_t;

	typedef struct packed {
		outcome_t           outcome;
		logic [ADDR_W-1:0]  granted_address;
		logic [BYTES_W-1:0] occupied_bytes;
		logic [BYTES_W-1:0] free_bytes;
		logic [BYTES_W-1:0] total_bytes;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_EVAL,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_WRITE,
		ST_MUL_USED,
		ST_MUL_FREE,
		ST_MUL_TOTAL,
		ST_MUL_START,
		ST_ADDR,
		ST_DONE
	} state_t;

endpackage

/* sv/ffba_div.sv */
// ----------------------------------------------------------------------------
// ffba_div
// Restoring divider, one quotient bit per cycle, shared by both request kinds.
// ----------------------------------------------------------------------------
module ffba_div import ffba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [BS_W-1:0]  divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [BS_W-1:0]  remainder
);

	localparam int CNT_BITS = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]    quo_q;
	logic [BS_W-1:0]     rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [BS_W:0]       trial;
	logic                ge;
	logic [BS_W:0]       diff;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	// Control: count the iterations, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* sv/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a region of equal blocks, with per-block free map.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | in_data  (req_t)
//  out     | output    | out_valid / out_stall  | out_data (rsp_t)
//  cfg     | input     | cfg_wr_en              | cfg_index, cfg_wdata
//
// Allocate: a division, a scan of the free map up to the managed block count,
// a write of each granted block, then bookkeeping. Free: a division, a read
// of the start mark, a write of each returned block, then bookkeeping. The
// divider is bit-serial. After reset and after each write to a listed
// register a clearing pass over all MAX_BLOCKS entries runs; in_stall stays
// high during it and while an item is at work.
// A finished result waits in the output register while the next item starts.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  req_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rsp_t                  out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int                IDX_W = $clog2(MAX_BLOCKS);
	localparam logic [ADDR_W-1:0] HDR   = ADDR_W'(HEADER_BYTES);
	localparam logic [ADDR_W-1:0] MAXB  = ADDR_W'(MAX_BLOCKS);
	localparam logic [IDX_W-1:0]  LAST  = IDX_W'(MAX_BLOCKS - 1);

	function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] v);
		return IDX_W'(ADDR_W'(v));
	endfunction

	// Configuration registers
	logic [ADDR_W-1:0] base_q;
	logic [BS_W-1:0]   bsize_q;
	logic [CNT_W-1:0]  mblk_q;
	logic              cfg_rebuild;
	logic [BS_W-1:0]   bs_eff;
	logic [CNT_W-1:0]  nblk;

	// Sequencer and datapath registers
	state_t           state_q, state_n;
	logic             mode_q;
	outcome_t         outcome_q;
	logic [IDX_W-1:0] clr_pos_q;
	logic [CNT_W-1:0] need_q;
	logic [CNT_W-1:0] issue_pos_q;
	logic [CNT_W-1:0] chk_pos_s1;
	logic             chk_vld_s1;
	logic [CNT_W-1:0] run_q;
	logic [CNT_W-1:0] start_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] wr_pos_q;
	logic [CNT_W-1:0] wr_left_q;
	logic             wr_val_q;
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] used_cnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [BYTES_W-1:0] occ_b_q;
	logic [BYTES_W-1:0] free_b_q;
	logic [BYTES_W-1:0] total_b_q;
	logic [ADDR_W-1:0] granted_q;
	logic             out_valid_q;
	rsp_t             out_q;

	// Memories and their ports
	logic             free_mem  [MAX_BLOCKS];
	logic             start_mem [MAX_BLOCKS];
	logic [CNT_W-1:0] len_mem   [MAX_BLOCKS];
	logic             free_rd_q;
	logic             start_rd_q;
	logic [CNT_W-1:0] len_rd_q;
	logic             free_we, free_wd;
	logic [IDX_W-1:0] free_wa;
	logic             start_we, start_wd, len_we;
	logic [IDX_W-1:0] start_wa;
	logic [CNT_W-1:0] len_wd;
	logic [IDX_W-1:0] rd_addr;
	logic             scan_issue;

	// Divider and multiplier
	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic [BS_W-1:0]  div_rem;
	logic [CNT_W-1:0] mul_a;
	logic [PROD_W-1:0] mul_p;

	// Status terms
	logic             in_acc;
	logic             out_free;
	logic             alloc_ok;
	logic             free_ok;
	logic             issue_ok;
	logic             hit;
	logic             scan_fail;
	logic [CNT_W-1:0] found_start;
	logic             wr_go;
	logic             clr_last;

	// Decode register writes; index past the list is dropped
	always_comb begin
		case (cfg_index)
			CFG_BASE, CFG_BSIZE, CFG_NBLK: cfg_rebuild = cfg_wr_en;
			default:                       cfg_rebuild = 1'b0;
		endcase
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bsize_q <= 17'd4096;
			mblk_q  <= 11'd1024;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_wdata;
				CFG_BSIZE: bsize_q <= cfg_wdata[BS_W-1:0];
				CFG_NBLK:  mblk_q  <= cfg_wdata[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	// Clamp block size and block count
	always_comb begin
		if (bsize_q == '0)
			bs_eff = BS_W'(1);
		else if (bsize_q > BS_CAP)
			bs_eff = BS_CAP;
		else
			bs_eff = bsize_q;
		nblk = (ADDR_W'(mblk_q) > MAXB) ? CNT_W'(MAXB) : mblk_q;
	end

	ffba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (bs_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Status terms used by both sequencer blocks
	always_comb begin
		in_acc      = in_valid && (state_q == ST_IDLE);
		out_free    = !out_valid_q || !out_stall;
		alloc_ok    = div_quo < DVD_W'(free_cnt_q);
		free_ok     = (div_rem == '0) && (div_quo < DVD_W'(nblk));
		issue_ok    = issue_pos_q < nblk;
		hit         = chk_vld_s1 && free_rd_q && ((run_q + 1'b1) >= need_q);
		scan_fail   = !issue_ok && !chk_vld_s1;
		found_start = (run_q == '0) ? chk_pos_s1 : start_q;
		wr_go       = (wr_left_q != '0) && (wr_pos_q < nblk);
		clr_last    = clr_pos_q == LAST;
		// Offset wraps at 32 bits before it is widened for the divider
		if (in_data.mode == MODE_ALLOC)
			div_dvd = DVD_W'(in_data.request_bytes) + DVD_W'(HDR);
		else
			div_dvd = {1'b0, in_data.release_address - HDR - base_q};
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR:    if (clr_last) state_n = ST_IDLE;
			ST_IDLE:     if (in_acc) state_n = ST_DIV;
			ST_DIV:      if (div_done) state_n = ST_EVAL;
			ST_EVAL: begin
				if (mode_q == MODE_ALLOC)
					state_n = alloc_ok ? ST_SCAN : ST_MUL_USED;
				else
					state_n = free_ok ? ST_FREE_RD : ST_MUL_USED;
			end
			ST_SCAN: begin
				if (hit)
					state_n = ST_WRITE;
				else if (scan_fail)
					state_n = ST_MUL_USED;
			end
			ST_FREE_RD:  state_n = ST_FREE_CHK;
			ST_FREE_CHK: state_n = start_rd_q ? ST_WRITE : ST_MUL_USED;
			ST_WRITE:    if (!wr_go) state_n = ST_MUL_USED;
			ST_MUL_USED: state_n = ST_MUL_FREE;
			ST_MUL_FREE: state_n = ST_MUL_TOTAL;
			ST_MUL_TOTAL: state_n = ST_MUL_START;
			ST_MUL_START: state_n = ST_ADDR;
			ST_ADDR:     state_n = ST_DONE;
			ST_DONE:     if (out_free) state_n = ST_IDLE;
			default:     state_n = ST_CLEAR;
		endcase
		if (cfg_rebuild)
			state_n = ST_CLEAR;
	end

	// Sequencer outputs: memory ports, divider start, multiplier operand
	always_comb begin
		free_we    = 1'b0;
		free_wa    = to_idx(wr_pos_q);
		free_wd    = wr_val_q;
		start_we   = 1'b0;
		start_wa   = to_idx(idx_q);
		start_wd   = 1'b0;
		len_we     = 1'b0;
		len_wd     = need_q;
		rd_addr    = to_idx(idx_q);
		scan_issue = 1'b0;
		div_start  = 1'b0;
		mul_a      = used_cnt_q;
		in_stall   = state_q != ST_IDLE;
		case (state_q)
			ST_CLEAR: begin
				free_we  = 1'b1;
				free_wa  = clr_pos_q;
				free_wd  = ADDR_W'(clr_pos_q) < ADDR_W'(nblk);
				start_we = 1'b1;
				start_wa = clr_pos_q;
			end
			ST_IDLE: div_start = in_acc;
			ST_SCAN: begin
				rd_addr    = to_idx(issue_pos_q);
				scan_issue = issue_ok;
				if (hit) begin
					start_we = 1'b1;
					start_wa = to_idx(found_start);
					start_wd = 1'b1;
					len_we   = 1'b1;
				end
			end
			ST_FREE_CHK: start_we = start_rd_q;
			ST_WRITE:    free_we = wr_go;
			ST_MUL_FREE:  mul_a = free_cnt_q;
			ST_MUL_TOTAL: mul_a = nblk;
			ST_MUL_START: mul_a = start_q;
			default: ;
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(bs_eff);

	// Memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (free_we)
			free_mem[free_wa] <= free_wd;
		if (start_we)
			start_mem[start_wa] <= start_wd;
		if (len_we)
			len_mem[start_wa] <= len_wd;
		free_rd_q  <= free_mem[rd_addr];
		start_rd_q <= start_mem[rd_addr];
		len_rd_q   <= len_mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_pos_q   <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			free_cnt_q  <= '0;
			used_cnt_q  <= '0;
		end else begin
			state_q    <= state_n;
			chk_vld_s1 <= scan_issue;

			// Sweep the maps; restart on every rebuild
			if (cfg_rebuild)
				clr_pos_q <= '0;
			else if (state_q == ST_CLEAR)
				clr_pos_q <= clr_pos_q + 1'b1;

			// Block counts
			if (state_q == ST_CLEAR) begin
				free_cnt_q <= nblk;
				used_cnt_q <= '0;
			end else if (state_q == ST_SCAN && hit) begin
				free_cnt_q <= free_cnt_q - need_q;
				used_cnt_q <= used_cnt_q + need_q;
			end else if (state_q == ST_FREE_CHK && start_rd_q) begin
				free_cnt_q <= free_cnt_q + len_rd_q;
				used_cnt_q <= used_cnt_q - len_rd_q;
			end

			// Output register: load on a free slot, drop on transfer
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mode_q    <= in_data.mode;
					outcome_q <= OUT_DONE;
				end
			end
			ST_EVAL: begin
				need_q      <= CNT_W'(div_quo) + 1'b1;
				idx_q       <= CNT_W'(div_quo);
				issue_pos_q <= '0;
				run_q       <= '0;
				if (mode_q == MODE_ALLOC && !alloc_ok)
					outcome_q <= OUT_NO_SPACE;
				if (mode_q == MODE_FREE && !free_ok)
					outcome_q <= OUT_NOT_ALLOC;
			end
			ST_SCAN: begin
				// Advance the read side, then track the run on returned bits
				if (issue_ok)
					issue_pos_q <= issue_pos_q + 1'b1;
				chk_pos_s1 <= issue_pos_q;
				if (chk_vld_s1) begin
					if (free_rd_q) begin
						run_q <= run_q + 1'b1;
						if (run_q == '0)
							start_q <= chk_pos_s1;
					end else begin
						run_q <= '0;
					end
				end
				if (hit) begin
					start_q   <= found_start;
					wr_pos_q  <= found_start;
					wr_left_q <= need_q;
					wr_val_q  <= 1'b0;
				end else if (scan_fail) begin
					outcome_q <= OUT_NO_SPACE;
				end
			end
			ST_FREE_CHK: begin
				if (start_rd_q) begin
					wr_pos_q  <= idx_q;
					wr_left_q <= len_rd_q;
					wr_val_q  <= 1'b1;
				end else begin
					outcome_q <= OUT_NOT_ALLOC;
				end
			end
			ST_WRITE: begin
				if (wr_go) begin
					wr_pos_q  <= wr_pos_q + 1'b1;
					wr_left_q <= wr_left_q - 1'b1;
				end
			end
			ST_MUL_FREE:  occ_b_q   <= prod_q[BYTES_W-1:0];
			ST_MUL_TOTAL: free_b_q  <= prod_q[BYTES_W-1:0];
			ST_MUL_START: total_b_q <= prod_q[BYTES_W-1:0];
			ST_ADDR: begin
				if (mode_q == MODE_ALLOC && outcome_q == OUT_DONE)
					granted_q <= base_q + ADDR_W'(prod_q) + HDR;
				else
					granted_q <= '0;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.outcome         <= outcome_q;
					out_q.granted_address <= granted_q;
					out_q.occupied_bytes  <= occ_b_q;
					out_q.free_bytes      <= free_b_q;
					out_q.total_bytes     <= total_b_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* tb/sv/first_fit_block_allocator_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A tracker class keeps
// its own block map, start marks and counters, predicts the result of every
// accepted request and compares each returned result field by field. Directed
// requests cover first fit, merging of freed neighbors, a full region and bad
// addresses; random phases then sweep the register settings, including their
// extremes, with random idling on both channels.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb import ffba_pkg::*;;

	// Tracker: block map, counters and the queue of predicted results
	class alloc_tracker;
		rsp_t              expected_rsp[$];
		logic [ADDR_W-1:0] live[$];
		logic [ADDR_W-1:0] last_freed;
		int                errors;
		logic [ADDR_W-1:0] base;
		logic [BS_W-1:0]   bsize;
		logic [CNT_W-1:0]  nblk;
		bit                free_map[MAX_BLOCKS_DEF];
		bit                start_map[MAX_BLOCKS_DEF];
		int unsigned       run_len[MAX_BLOCKS_DEF];
		int unsigned       free_cnt;
		int unsigned       used_cnt;

		function new();
			base       = '0;
			bsize      = 4096;
			nblk       = 1024;
			errors     = 0;
			last_freed = '0;
			clear_region();
		endfunction

		// Zero means one byte; clip at the largest block
		function int unsigned block_bytes();
			if (bsize == 0) return 1;
			if (bsize > BS_CAP) return BS_CAP;
			return bsize;
		endfunction

		function int unsigned block_total();
			return (nblk > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : nblk;
		endfunction

		function void clear_region();
			for (int i = 0; i < MAX_BLOCKS_DEF; i++) begin
				free_map[i]  = (i < block_total());
				start_map[i] = 1'b0;
				run_len[i]   = 0;
			end
			free_cnt = block_total();
			used_cnt = 0;
			live.delete();
		endfunction

		// Any write to a listed register rebuilds the region
		function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_BASE:  base  = val;
				CFG_BSIZE: bsize = val[BS_W-1:0];
				CFG_NBLK:  nblk  = val[CNT_W-1:0];
				default:   return;
			endcase
			clear_region();
		endfunction

		// Apply one accepted request and queue its result
		function void note_request(req_t rq);
			longint unsigned   bs;
			longint unsigned   need;
			longint unsigned   idx;
			int unsigned       n;
			int unsigned       run;
			int unsigned       first;
			logic [ADDR_W-1:0] off;
			bit                found;
			rsp_t              r;
			bs      = block_bytes();
			n       = block_total();
			r       = '0;
			r.outcome = OUT_DONE;
			found   = 1'b0;
			run     = 0;
			first   = 0;
			if (rq.mode == MODE_ALLOC) begin
				need = rq.request_bytes;
				need = (need + HEADER_BYTES_DEF) / bs + 1;
				// first fit: lowest free run long enough
				if (need <= free_cnt) begin
					for (int i = 0; i < n; i++) begin
						if (free_map[i]) begin
							if (run == 0) first = i;
							run++;
							if (run >= need) begin
								found = 1'b1;
								break;
							end
						end else begin
							run = 0;
						end
					end
				end
				if (found) begin
					for (int i = first; i < first + need; i++) free_map[i] = 1'b0;
					start_map[first] = 1'b1;
					run_len[first]   = need;
					free_cnt        -= need;
					used_cnt        += need;
					r.granted_address = base + first * bs + HEADER_BYTES_DEF;
					live.push_back(r.granted_address);
				end else begin
					r.outcome = OUT_NO_SPACE;
				end
			end else begin
				off = rq.release_address - ADDR_W'(HEADER_BYTES_DEF) - base;
				idx = off / bs;
				if (off % bs == 0 && idx < n && start_map[idx]) begin
					for (int i = idx; i < idx + run_len[idx] && i < n; i++) free_map[i] = 1'b1;
					start_map[idx] = 1'b0;
					free_cnt      += run_len[idx];
					used_cnt      -= run_len[idx];
					last_freed     = rq.release_address;
					for (int j = 0; j < live.size(); j++) begin
						if (live[j] == rq.release_address) begin
							live.delete(j);
							break;
						end
					end
				end else begin
					r.outcome = OUT_NOT_ALLOC;
				end
			end
			r.occupied_bytes = used_cnt * bs;
			r.free_bytes     = free_cnt * bs;
			r.total_bytes    = n * bs;
			expected_rsp.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		// Compare one returned result with the oldest prediction
		task check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			want = expected_rsp.pop_front();
			if (got.outcome !== want.outcome)
				report($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
			if (got.granted_address !== want.granted_address)
				report($sformatf("granted_address got %h want %h",
					got.granted_address, want.granted_address));
			if (got.occupied_bytes !== want.occupied_bytes)
				report($sformatf("occupied_bytes got %0d want %0d",
					got.occupied_bytes, want.occupied_bytes));
			if (got.free_bytes !== want.free_bytes)
				report($sformatf("free_bytes got %0d want %0d", got.free_bytes, want.free_bytes));
			if (got.total_bytes !== want.total_bytes)
				report($sformatf("total_bytes got %0d want %0d",
					got.total_bytes, want.total_bytes));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	req_t                  in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	rsp_t                  out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	bit                    quiet     = 1'b0;
	int unsigned           hold_left = 0;

	alloc_tracker sb = new();

	first_fit_block_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check each result transfer; stall the output at random, with rare long holds
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_response(out_data);
		if (quiet) begin
			hold_left <= 0;
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(999) < 2) begin
			hold_left <= $urandom_range(120, 20);
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < 15);
		end
	end

	// Offer one request and hold it until the transfer; then maybe idle
	task automatic send(input req_t rq);
		in_data  <= rq;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(rq);
		if (!quiet && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			if ($urandom_range(99) < 10) repeat ($urandom_range(80, 20)) @(posedge clk);
			else repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic alloc_req(input logic [ADDR_W-1:0] bytes);
		req_t r;
		r.mode            = MODE_ALLOC;
		r.request_bytes   = bytes;
		r.release_address = $urandom();
		send(r);
	endtask

	task automatic free_req(input logic [ADDR_W-1:0] addr);
		req_t r;
		r.mode            = MODE_FREE;
		r.request_bytes   = $urandom();
		r.release_address = addr;
		send(r);
	endtask

	// Write one register once the block is drained and not clearing
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (sb.expected_rsp.size() != 0) @(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_config(idx, val);
		// let the clearing pass start and finish
		for (int i = 0; i < 4 && in_stall === 1'b0; i++) @(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic set_region(input logic [31:0] base, input logic [31:0] bsize,
			input logic [31:0] nblk);
		write_reg(CFG_BASE, base);
		write_reg(CFG_BSIZE, bsize);
		write_reg(CFG_NBLK, nblk);
	endtask

	// Default region: 4 KiB blocks at address zero
	task automatic run_directed();
		alloc_req(32'd0);            // block 0
		alloc_req(32'd4064);         // header pushes it to two blocks
		alloc_req(32'd4063);         // exactly one block
		alloc_req(32'hFFFF_FFFF);    // far beyond the region
		free_req(32'd8224);          // inner block of a live allocation
		free_req(32'd4128);          // two-block allocation
		free_req(32'd4128);          // double free
		free_req(32'd12321);         // misaligned
		free_req(32'd0);             // wraps below the base
		free_req(32'hFFFF_FFFF);
		free_req(32'd12320);         // neighbor merges with the hole
		alloc_req(32'd12255);        // three blocks fit the merged hole
		alloc_req(32'd0);
		alloc_req(32'd4169696);      // rest of the region
		alloc_req(32'd0);            // region full
		free_req(32'd32);
		alloc_req(32'd4064);         // one block free, two needed
		free_req(32'd4128);
		free_req(32'd16416);
		free_req(32'd20512);
		alloc_req(32'd4190176);      // whole region at once
		free_req(32'd32);
	endtask

	// Mostly valid alloc/free sequences, some bad addresses and huge requests
	task automatic run_random(input int count);
		req_t            r;
		longint unsigned bs;
		longint unsigned span;
		int unsigned     n;
		int unsigned     k;
		int unsigned     j;
		int              pick;
		for (int i = 0; i < count; i++) begin
			bs = sb.block_bytes();
			n  = sb.block_total();
			r.mode            = MODE_ALLOC;
			r.request_bytes   = $urandom();
			r.release_address = $urandom();
			pick = $urandom_range(99);
			if (pick >= 45 && pick < 80 && sb.live.size() == 0) pick = 0;
			if (pick < 45) begin
				// size the request in whole blocks
				if ($urandom_range(99) < 6) k = $urandom_range(n > 0 ? n : 1, 1);
				else k = $urandom_range(bs < 64 ? 96 : 4, 1);
				span = longint'(k - 1) * bs + $urandom_range(bs - 1, 0);
				r.request_bytes = (span >= HEADER_BYTES_DEF) ?
					span - HEADER_BYTES_DEF : $urandom_range(3, 0);
			end else if (pick < 80) begin
				r.mode            = MODE_FREE;
				r.release_address = sb.live[$urandom_range(sb.live.size() - 1, 0)];
			end else begin
				case (pick % 4)
					0: ;
					1: r.mode = MODE_FREE;
					2: begin
						r.mode = MODE_FREE;
						if (sb.live.size() != 0) begin
							j = $urandom_range(sb.live.size() - 1, 0);
							if ($urandom_range(1)) r.release_address = sb.live[j] + $urandom_range(bs, 1);
							else r.release_address = sb.live[j] - $urandom_range(bs, 1);
						end
					end
					default: begin
						r.mode            = MODE_FREE;
						r.release_address = sb.last_freed;
					end
				endcase
			end
			send(r);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random(60);
		set_region(32'hFFFF_FFC0, 32'd0, 32'd2047);
		run_random(60);
		set_region(32'hFFFF_FFFF, 32'd131071, 32'd1);
		run_random(40);
		set_region(32'h0000_1000, 32'd1, 32'd0);
		run_random(25);
		set_region($urandom(), 32'd65536, 32'd1024);
		run_random(40);
		set_region($urandom(), $urandom_range(100000, 2), $urandom_range(64, 2));
		quiet <= 1'b1;
		run_random(80);
		quiet <= 1'b0;
		run_random(120);
		set_region(32'd0, 32'd48, 32'd1024);
		run_random(150);
		in_valid <= 1'b0;
		while (sb.expected_rsp.size() != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
		if (sb.errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	// Bound the run
	initial begin
		#64_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
